[rtl/core/assert_macros.svh]
// ----------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion forms for the checker files.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked assertion, disabled while reset is high.
`define ASSERT_CLK(label, clk, rst, prop, msg) \
   label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Clocked assertion that also holds through reset.
`define ASSERT_CLK_NR(label, clk, prop, msg) \
   label: assert property (@(posedge clk) prop) else $error(msg);

`endif

[rtl/core/tssd_pkg.sv]
// ----------------------------------------------------------------------------
// tssd_pkg
// Widths, scale constants, segment table and payload types of the driver.
// ----------------------------------------------------------------------------
package tssd_pkg;

   localparam int SAMPLE_W = 10;
   localparam int BYTE_W   = 8;
   localparam int DIGIT_W  = 4;
   localparam int DEG_W    = 8;
   localparam int PROD_W   = 18;   // 1023 * 198 fits in 18 bits
   localparam int REM_W    = 19;   // division remainder estimate, 0..2045

   localparam logic [DEG_W-1:0]  CEL_SCALE   = 8'd110;
   localparam logic [DEG_W-1:0]  FAHR_SCALE  = 8'd198;
   localparam logic [DEG_W-1:0]  FAHR_OFFSET = 8'd32;
   localparam logic [REM_W-1:0]  DIV_BASE    = 19'd1023;
   localparam int                DIV_SHIFT   = 10;

   localparam logic [BYTE_W-1:0] FIRST_SELECT = 8'h10;

   typedef struct packed {
      logic [SAMPLE_W-1:0] sample;
      logic                fahr;
   } sample_type;

   // Active-low segment codes for digits 0..9.
   function automatic logic [BYTE_W-1:0] seg_code(input logic [DIGIT_W-1:0] digit);
      logic [BYTE_W-1:0] code;
      case (digit)
         4'd0:    code = 8'h03;
         4'd1:    code = 8'h9F;
         4'd2:    code = 8'h25;
         4'd3:    code = 8'h0D;
         4'd4:    code = 8'h99;
         4'd5:    code = 8'h49;
         4'd6:    code = 8'h41;
         4'd7:    code = 8'h1F;
         4'd8:    code = 8'h01;
         4'd9:    code = 8'h09;
         default: code = 8'h03;
      endcase
      return code;
   endfunction

endpackage

[rtl/core/tssd_if.sv]
// ----------------------------------------------------------------------------
// tssd_if
// Valid/ready channels for converter samples and digit results.
// ----------------------------------------------------------------------------
interface tssd_req_if import tssd_pkg::*; ();
   logic                valid;
   logic                ready;
   logic [SAMPLE_W-1:0] adc_sample;

   modport source (output valid, output adc_sample, input ready);
   modport sink   (input valid, input adc_sample, output ready);
endinterface

interface tssd_rsp_if import tssd_pkg::*; ();
   logic              valid;
   logic              ready;
   logic [BYTE_W-1:0] segment_pattern;
   logic [BYTE_W-1:0] digit_select;
   logic              last_digit;

   modport source (output valid, output segment_pattern, output digit_select,
                   output last_digit, input ready);
   modport sink   (input valid, input segment_pattern, input digit_select,
                   input last_digit, output ready);
endinterface

[rtl/core/tssd_scale.sv]
// ----------------------------------------------------------------------------
// tssd_scale
// Three-stage sample to whole-degree scaler: multiply, divide estimate,
// remainder correction with Fahrenheit offset.
// ----------------------------------------------------------------------------
module tssd_scale import tssd_pkg::*; (
   input  logic              clock,
   input  logic              reset,
   input  logic              in_valid,
   output logic              in_ready,
   input  sample_type        in_data,
   output logic              out_valid,
   input  logic              out_ready,
   output logic [DEG_W-1:0]  out_degrees
);

   logic [2:0]              valid_ff, valid_in;
   logic [2:0]              adv;

   logic [PROD_W-1:0]       prod_ff, prod_in;
   logic                    fahr1_ff;
   logic [PROD_W-1:0]       prod2_ff;
   logic [DEG_W-1:0]        quot_ff, quot_in;
   logic                    fahr2_ff;
   logic [DEG_W-1:0]        deg_ff, deg_in;

   logic [PROD_W-1:0]       est_sum;
   logic [REM_W-1:0]        rem_est;
   logic [DEG_W-1:0]        quot_fix;

   // Advance a stage when it is empty or its content moves on.
   assign adv[2]   = !valid_ff[2] || out_ready;
   assign adv[1]   = !valid_ff[1] || adv[2];
   assign adv[0]   = !valid_ff[0] || adv[1];
   assign in_ready = adv[0];

   always_comb begin
      valid_in[0] = adv[0] ? in_valid    : valid_ff[0];
      valid_in[1] = adv[1] ? valid_ff[0] : valid_ff[1];
      valid_in[2] = adv[2] ? valid_ff[1] : valid_ff[2];
   end

   // Stage 1: product with the unit's scale.
   assign prod_in = PROD_W'(in_data.sample) *
                    PROD_W'(in_data.fahr ? FAHR_SCALE : CEL_SCALE);

   // Stage 2: p/1023 estimate as (p + p/1024)/1024, never high, at most one low.
   assign est_sum = prod_ff + (prod_ff >> DIV_SHIFT);
   assign quot_in = DEG_W'(est_sum >> DIV_SHIFT);

   // Stage 3: fix the estimate by the remainder, then add the offset.
   assign rem_est  = REM_W'(prod2_ff) - (REM_W'(quot_ff) << DIV_SHIFT) + REM_W'(quot_ff);
   assign quot_fix = quot_ff + DEG_W'(rem_est >= DIV_BASE);
   assign deg_in   = quot_fix + (fahr2_ff ? FAHR_OFFSET : '0);

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else begin
         valid_ff <= valid_in;
      end
      if (adv[0]) begin
         prod_ff  <= prod_in;
         fahr1_ff <= in_data.fahr;
      end
      if (adv[1]) begin
         prod2_ff <= prod_ff;
         quot_ff  <= quot_in;
         fahr2_ff <= fahr1_ff;
      end
      if (adv[2]) begin
         deg_ff <= deg_in;
      end
   end

   assign out_valid   = valid_ff[2];
   assign out_degrees = deg_ff;

endmodule

[rtl/core/tssd_digits.sv]
// ----------------------------------------------------------------------------
// tssd_digits
// Decimal split of the degree value and segment code lookup, one stage.
// ----------------------------------------------------------------------------
module tssd_digits import tssd_pkg::*; #(
   parameter int DIGIT_COUNT = 4
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              in_valid,
   output logic              in_ready,
   input  logic [DEG_W-1:0]  in_degrees,
   output logic              out_valid,
   input  logic              out_ready,
   output logic [BYTE_W-1:0] out_segs [DIGIT_COUNT]
);

   localparam int SPLIT_DIGITS = 3;   // values stay below 256

   logic                valid_ff;
   logic [BYTE_W-1:0]   segs_ff [DIGIT_COUNT];
   logic [BYTE_W-1:0]   segs_in [DIGIT_COUNT];

   logic [DIGIT_W-1:0]  hund;
   logic [DEG_W-1:0]    rem8;
   logic [6:0]          rem;
   logic [14:0]         tens_prod;
   logic [DIGIT_W-1:0]  tens;
   logic [DIGIT_W-1:0]  units;
   logic [DIGIT_W-1:0]  digit_val [SPLIT_DIGITS];

   assign in_ready = !valid_ff || out_ready;

   always_comb begin
      if (in_degrees >= 8'd200) begin
         hund = 4'd2;
         rem8 = in_degrees - 8'd200;
      end else if (in_degrees >= 8'd100) begin
         hund = 4'd1;
         rem8 = in_degrees - 8'd100;
      end else begin
         hund = 4'd0;
         rem8 = in_degrees;
      end
      rem       = rem8[6:0];
      // Divide by ten through the reciprocal 205/2048, exact below 1029.
      tens_prod = 15'(rem) * 15'd205;
      tens      = DIGIT_W'(tens_prod >> 11);
      units     = DIGIT_W'(rem - 7'(tens) * 7'd10);
      digit_val[0] = units;
      digit_val[1] = tens;
      digit_val[2] = hund;
      for (int i = 0; i < DIGIT_COUNT; i++) begin
         if (i < SPLIT_DIGITS) begin
            segs_in[i] = seg_code(digit_val[i]);
         end else begin
            segs_in[i] = seg_code('0);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (in_ready) begin
         valid_ff <= in_valid;
      end
      if (in_ready) begin
         segs_ff <= segs_in;
      end
   end

   assign out_valid = valid_ff;
   assign out_segs  = segs_ff;

endmodule

[rtl/core/tssd_serial.sv]
// ----------------------------------------------------------------------------
// tssd_serial
// Output serializer: one digit result per transaction, last one marked.
// ----------------------------------------------------------------------------
module tssd_serial import tssd_pkg::*; #(
   parameter int DIGIT_COUNT = 4
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              in_valid,
   output logic              in_ready,
   input  logic [BYTE_W-1:0] in_segs [DIGIT_COUNT],
   tssd_rsp_if.source        rsp_chan
);

   localparam int IDX_W = (DIGIT_COUNT > 1) ? $clog2(DIGIT_COUNT) : 1;
   localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(DIGIT_COUNT - 1);

   logic               busy_ff;
   logic [IDX_W-1:0]   idx_ff;
   logic [BYTE_W-1:0]  segs_ff [DIGIT_COUNT];

   logic               is_last;
   logic               take;
   logic               load;
   logic [3:0]         pos;

   assign is_last  = (idx_ff == LAST_IDX);
   assign take     = busy_ff && rsp_chan.ready;
   assign in_ready = !busy_ff || (rsp_chan.ready && is_last);
   assign load     = in_valid && in_ready;

   // Select bit position 4 + index; positions past bit 7 drop out.
   assign pos = 4'(idx_ff) + 4'd4;

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         idx_ff  <= '0;
      end else if (load) begin
         busy_ff <= 1'b1;
         idx_ff  <= '0;
      end else if (take) begin
         if (is_last) begin
            busy_ff <= 1'b0;
         end else begin
            idx_ff <= idx_ff + 1'b1;
         end
      end
      if (load) begin
         segs_ff <= in_segs;
      end else if (take) begin
         for (int k = 0; k < DIGIT_COUNT - 1; k++) begin
            segs_ff[k] <= segs_ff[k + 1];
         end
      end
   end

   assign rsp_chan.valid           = busy_ff;
   assign rsp_chan.segment_pattern = segs_ff[0];
   assign rsp_chan.digit_select    = (pos < 4'd8) ? (FIRST_SELECT << idx_ff) : '0;
   assign rsp_chan.last_digit      = is_last;

endmodule

[rtl/core/temperature_seven_segment_driver.sv]
// ----------------------------------------------------------------------------
// temperature_seven_segment_driver
// Converter sample to whole degrees to per-digit seven-segment results.
// ----------------------------------------------------------------------------
// Each accepted 10-bit converter sample becomes DIGIT_COUNT result
// transactions, least significant digit first: the active-low segment code
// of the digit, a one-hot select byte (16 for units, 32 tens, 64 hundreds,
// 128 thousands, 0 beyond) and last_digit set on the final one. The value is
// floor(s*110/1023) in Celsius or floor(s*198/1023)+32 in Fahrenheit, as
// csr_write_data picks when csr_write_en is high; change it only while idle.
// Throughput is one result per cycle while the result side is ready; the
// output serializer limits the sample rate. A sample passes a five-stage
// path (multiply, divide estimate, correction, digit split, serializer),
// registered at each stage before its first result is presented. A new
// sample is taken while results still wait.
// ----------------------------------------------------------------------------
module temperature_seven_segment_driver import tssd_pkg::*; #(
   parameter int DIGIT_COUNT = 4
) (
   input  logic        clock,
   input  logic        reset,
   tssd_req_if.sink    req_chan,
   tssd_rsp_if.source  rsp_chan,
   input  logic        csr_write_en,
   input  logic        csr_write_data
);

   logic              unit_fahrenheit_ff;
   sample_type        sample_data;

   logic              scale_valid;
   logic              scale_ready;
   logic [DEG_W-1:0]  scale_degrees;

   logic              digit_valid;
   logic              digit_ready;
   logic [BYTE_W-1:0] digit_segs [DIGIT_COUNT];

   // Hold the unit select; the user writes it only between samples (not enforced here).
   always_ff @(posedge clock) begin
      if (reset) begin
         unit_fahrenheit_ff <= 1'b0;
      end else if (csr_write_en) begin
         unit_fahrenheit_ff <= csr_write_data;
      end
   end

   // Tag each sample with the unit it is converted in.
   assign sample_data.sample = req_chan.adc_sample;
   assign sample_data.fahr   = unit_fahrenheit_ff;

   // Stages 1-3: scale to whole degrees.
   tssd_scale u_scale (
      .clock       (clock),
      .reset       (reset),
      .in_valid    (req_chan.valid),
      .in_ready    (req_chan.ready),
      .in_data     (sample_data),
      .out_valid   (scale_valid),
      .out_ready   (scale_ready),
      .out_degrees (scale_degrees)
   );

   // Stage 4: split into decimal digits and look up segment codes.
   tssd_digits #(
      .DIGIT_COUNT (DIGIT_COUNT)
   ) u_digits (
      .clock      (clock),
      .reset      (reset),
      .in_valid   (scale_valid),
      .in_ready   (scale_ready),
      .in_degrees (scale_degrees),
      .out_valid  (digit_valid),
      .out_ready  (digit_ready),
      .out_segs   (digit_segs)
   );

   // Stage 5: hand out one digit per result transaction.
   tssd_serial #(
      .DIGIT_COUNT (DIGIT_COUNT)
   ) u_serial (
      .clock    (clock),
      .reset    (reset),
      .in_valid (digit_valid),
      .in_ready (digit_ready),
      .in_segs  (digit_segs),
      .rsp_chan (rsp_chan)
   );

endmodule

[rtl/core/tssd_checker.sv]
// ----------------------------------------------------------------------------
// tssd_checker
// Port-level checks on the digit result sequence of the driver.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module tssd_checker import tssd_pkg::*; (
   input logic              clock,
   input logic              reset,
   input logic              rsp_valid,
   input logic              rsp_ready,
   input logic [BYTE_W-1:0] digit_select,
   input logic [BYTE_W-1:0] segment_pattern,
   input logic              last_digit
);

   logic rsp_take;

   assign rsp_take = rsp_valid && rsp_ready;

   `ASSERT_CLK_NR(a_idle_after_reset, clock, reset |=> !rsp_valid, "result valid right after reset")

   `ASSERT_CLK(a_stall_hold, clock, reset, rsp_valid && !rsp_ready |=> rsp_valid && $stable(segment_pattern) && $stable(digit_select) && $stable(last_digit), "stalled result changed")

   `ASSERT_CLK(a_select_walks, clock, reset, rsp_take && !last_digit |=> rsp_valid && digit_select == 8'($past(digit_select) << 1), "digit select did not advance")

   `ASSERT_CLK(a_first_digit, clock, reset, rsp_take && last_digit |=> !rsp_valid || digit_select == FIRST_SELECT, "sample did not start at the units digit")

endmodule

bind temperature_seven_segment_driver tssd_checker u_tssd_checker (
   .clock           (clock),
   .reset           (reset),
   .rsp_valid       (rsp_chan.valid),
   .rsp_ready       (rsp_chan.ready),
   .digit_select    (rsp_chan.digit_select),
   .segment_pattern (rsp_chan.segment_pattern),
   .last_digit      (rsp_chan.last_digit)
);

[tb/sv/tssd_digit_checker.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tssd_digit_checker
// Watches the sample, digit and unit-select ports of the seven-segment
// driver, predicts the digit transactions of every accepted sample and
// compares them in order with what the block hands out.
// ----------------------------------------------------------------------------
module tssd_digit_checker import tssd_pkg::*; #(
   parameter int DIGIT_COUNT = 4
) (
   input  logic clock,
   input  logic reset,
   tssd_req_if  req_chan,
   tssd_rsp_if  rsp_chan,
   input  logic csr_write_en,
   input  logic csr_write_data,
   output int   fail_count,
   output int   digits_pending
);

   typedef struct packed {
      logic [BYTE_W-1:0] segment;
      logic [BYTE_W-1:0] select;
      logic              last;
   } digit_result_type;

   digit_result_type digits_due[$];
   logic             show_fahrenheit;
   int               errors = 0;

   function automatic logic [BYTE_W-1:0] glyph_for(input int unsigned digit);
      case (digit)
         0:       return 8'h03;
         1:       return 8'h9F;
         2:       return 8'h25;
         3:       return 8'h0D;
         4:       return 8'h99;
         5:       return 8'h49;
         6:       return 8'h41;
         7:       return 8'h1F;
         8:       return 8'h01;
         default: return 8'h09;
      endcase
   endfunction

   // Scale to whole degrees, then queue one digit per position, units first.
   function automatic void expand_reading(input logic [SAMPLE_W-1:0] sample,
                                          input logic fahr);
      int unsigned      degrees;
      digit_result_type digit;
      if (fahr)
         degrees = (int'(sample) * 198) / 1023 + 32;
      else
         degrees = (int'(sample) * 110) / 1023;
      for (int i = 0; i < DIGIT_COUNT; i++) begin
         digit.segment = glyph_for(degrees % 10);
         digit.select  = (4 + i < 8) ? BYTE_W'(1 << (4 + i)) : '0;
         digit.last    = (i == DIGIT_COUNT - 1);
         degrees       = degrees / 10;
         digits_due.push_back(digit);
      end
   endfunction

   always @(posedge clock) begin
      digit_result_type want;
      if (reset) begin
         show_fahrenheit = 1'b0;
         digits_due.delete();
      end else begin
         // check the result side first: a digit can never belong to a sample
         // taken at the same edge
         if (rsp_chan.valid && rsp_chan.ready) begin
            if (digits_due.size() == 0) begin
               errors++;
               $display("%0t: unexpected digit transaction: seg %h sel %h last %b",
                        $time, rsp_chan.segment_pattern, rsp_chan.digit_select,
                        rsp_chan.last_digit);
            end else begin
               want = digits_due.pop_front();
               if (want.segment !== rsp_chan.segment_pattern) begin
                  errors++;
                  $display("%0t: segment_pattern expected %h actual %h", $time,
                           want.segment, rsp_chan.segment_pattern);
               end
               if (want.select !== rsp_chan.digit_select) begin
                  errors++;
                  $display("%0t: digit_select expected %h actual %h", $time,
                           want.select, rsp_chan.digit_select);
               end
               if (want.last !== rsp_chan.last_digit) begin
                  errors++;
                  $display("%0t: last_digit expected %b actual %b", $time,
                           want.last, rsp_chan.last_digit);
               end
            end
         end
         if (req_chan.valid && req_chan.ready)
            expand_reading(req_chan.adc_sample, show_fahrenheit);
         if (csr_write_en)
            show_fahrenheit = csr_write_data;
      end
      digits_pending <= digits_due.size();
      fail_count     <= errors;
   end

endmodule

[tb/sv/temperature_seven_segment_driver_test.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// temperature_seven_segment_driver_test
// Drives converter samples through the seven-segment driver in Celsius and
// Fahrenheit, first corner readings, then random ones; all but the last random
// phase add random gaps on the sample side and random stalls on the digit side;
// a checker beside the block predicts every digit transaction and counts mismatches.
// ----------------------------------------------------------------------------
module temperature_seven_segment_driver_test;
   import tssd_pkg::*;

   localparam int  DIGITS        = 4;
   localparam int  RANDOM_PHASES = 4;
   localparam int  PHASE_ITEMS   = 39;
   localparam int  DRAIN_LIMIT   = 5000;
   localparam int  SETTLE_CYCLES = 20;       // well past the five-stage path
   localparam time TIMEOUT_NS    = 2_000_000;

   logic clock;
   logic reset;
   logic csr_write_en;
   logic csr_write_data;
   logic idle_on;
   int   stall_left = 0;
   int   mismatch_count;
   int   digits_pending;

   // readings around the scale's digit rollovers, both ends of the range
   int unsigned corner_samples [12] = '{0, 1, 9, 10, 93, 94, 465, 929, 930, 1000,
                                        1022, 1023};

   tssd_req_if req_chan ();
   tssd_rsp_if rsp_chan ();

   temperature_seven_segment_driver #(
      .DIGIT_COUNT(DIGITS)
   ) DUT (
      .clock          (clock),
      .reset          (reset),
      .req_chan       (req_chan),
      .rsp_chan       (rsp_chan),
      .csr_write_en   (csr_write_en),
      .csr_write_data (csr_write_data)
   );

   tssd_digit_checker #(
      .DIGIT_COUNT(DIGITS)
   ) checker_i (
      .clock          (clock),
      .reset          (reset),
      .req_chan       (req_chan),
      .rsp_chan       (rsp_chan),
      .csr_write_en   (csr_write_en),
      .csr_write_data (csr_write_data),
      .fail_count     (mismatch_count),
      .digits_pending (digits_pending)
   );

   initial begin
      clock = 1'b0;
   end

   always #5 clock = ~clock;

   // Result-side back-pressure: drop ready in random bursts while
   // idling is enabled, otherwise hold it high.
   always @(posedge clock) begin
      if (stall_left > 0) begin
         rsp_chan.ready <= 1'b0;
         stall_left     <= stall_left - 1;
      end else if (idle_on && $urandom_range(0, 5) == 0) begin
         rsp_chan.ready <= 1'b0;
         stall_left     <= $urandom_range(1, 9) - 1;
      end else begin
         rsp_chan.ready <= 1'b1;
      end
   end

   // Present one sample and hold it until the transaction completes. With
   // idling on, sometimes drop valid for a burst first.
   task automatic send_sample(input logic [SAMPLE_W-1:0] reading);
      if (idle_on && $urandom_range(0, 3) == 0) begin
         req_chan.valid <= 1'b0;
         repeat ($urandom_range(1, 9)) @(posedge clock);
      end
      req_chan.valid      <= 1'b1;
      req_chan.adc_sample <= reading;
      do @(posedge clock); while (!req_chan.ready);
   endtask

   // Drop valid and wait until every predicted digit has come out. Every
   // sample yields digits, so an empty queue means the block is idle.
   task automatic drain_digits();
      int waited;
      waited = 0;
      req_chan.valid <= 1'b0;
      @(posedge clock);
      while (digits_pending != 0 && waited < DRAIN_LIMIT) begin
         @(posedge clock);
         waited++;
      end
   endtask

   // Select the display unit; only call with the block idle.
   task automatic write_unit(input logic fahr);
      csr_write_en   <= 1'b1;
      csr_write_data <= fahr;
      @(posedge clock);
      csr_write_en   <= 1'b0;
   endtask

   // Mostly uniform readings, with the range ends forced now and then.
   function automatic logic [SAMPLE_W-1:0] pick_sample();
      case ($urandom_range(0, 15))
         0:       return '0;
         1:       return '1;
         2:       return SAMPLE_W'(1);
         3:       return SAMPLE_W'(1022);
         default: return SAMPLE_W'($urandom_range(0, 1023));
      endcase
   endfunction

   // Stimulus and verdict.
   initial begin
      // hold the sample and unit inputs at known values from time zero; the
      // result ready settles at the first edge
      reset               = 1'b1;
      idle_on             = 1'b0;
      csr_write_en        = 1'b0;
      csr_write_data      = 1'b0;
      req_chan.valid      = 1'b0;
      req_chan.adc_sample = '0;

      repeat (3) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // corner readings in Celsius, then in Fahrenheit, with idling on
      idle_on = 1'b1;
      write_unit(1'b0);
      foreach (corner_samples[i])
         send_sample(SAMPLE_W'(corner_samples[i]));
      drain_digits();
      write_unit(1'b1);
      foreach (corner_samples[i])
         send_sample(SAMPLE_W'(corner_samples[i]));
      drain_digits();

      // random readings, alternating the unit between phases; run the last
      // phase flat out on both sides
      for (int phase = 0; phase < RANDOM_PHASES; phase++) begin
         write_unit(phase % 2 == 0);
         idle_on = (phase < RANDOM_PHASES - 1);
         for (int n = 0; n < PHASE_ITEMS; n++)
            send_sample(pick_sample());
         drain_digits();
      end

      // let any stray transaction surface before judging
      repeat (SETTLE_CYCLES) @(posedge clock);

      if (digits_pending != 0)
         $display("%0t: %0d digit transactions never arrived", $time, digits_pending);
      if (mismatch_count == 0 && digits_pending == 0) begin
         $display("simulation ok");
      end else begin
         $display("simulation failed");
      end
      $finish;
   end

   // Watchdog against a hung handshake.
   initial begin
      #(TIMEOUT_NS);
      $display("simulation failed");
      $finish;
   end

endmodule

[files.f]
+incdir+rtl/core
rtl/core/tssd_pkg.sv
rtl/core/tssd_if.sv
rtl/core/tssd_scale.sv
rtl/core/tssd_digits.sv
rtl/core/tssd_serial.sv
rtl/core/temperature_seven_segment_driver.sv
rtl/core/tssd_checker.sv
tb/sv/tssd_digit_checker.sv
tb/sv/temperature_seven_segment_driver_test.sv
